/* design/rpi_pkg.sv */
// Shared types and constants for the ray-plane intersection block.
package rpi_pkg;

	localparam int unsigned NUM_DIV_STEPS = 32;
	localparam int unsigned NSH_W = 81;
	localparam int unsigned DMAG_W = 64;
	localparam int unsigned CMP_W = 96;

	localparam logic [31:0] DIST_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] DIST_MIN = 32'h8000_0000;

	localparam logic [2:0] REG_NORMAL_X = 3'd0;
	localparam logic [2:0] REG_NORMAL_Y = 3'd1;
	localparam logic [2:0] REG_NORMAL_Z = 3'd2;
	localparam logic [2:0] REG_POINT_X = 3'd3;
	localparam logic [2:0] REG_POINT_Y = 3'd4;
	localparam logic [2:0] REG_POINT_Z = 3'd5;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic signed [31:0] distance;
		logic no_hit;
		logic leaving;
		logic signed [31:0] surf_normal_x;
		logic signed [31:0] surf_normal_y;
		logic signed [31:0] surf_normal_z;
	} res_t;

	// Dot products handed from the front end to the divider.
	typedef struct packed {
		logic signed [65:0] den;
		logic signed [66:0] num;
	} dots_t;

	// Status that travels alongside the quotient.
	typedef struct packed {
		logic no_hit;
		logic neg;
		logic leaving;
		logic ovf;
	} dflag_t;

	// Quotient and status leaving the divider.
	typedef struct packed {
		logic [31:0] quot;
		dflag_t flags;
	} quo_t;

endpackage

/* design/ray_plane_intersect.sv */
// Top level of the ray-plane intersection block: registers, pipeline and result stage.
//
// One ray is taken on every clock edge at which start is high; busy is always low,
// so a ray may be offered in every cycle. Each ray gives exactly one result, shown
// for one cycle with done high. On the way, the dot-product stages form the two dot
// products with 32x32- and 32x33-bit multipliers, a stage takes magnitudes, a stage
// checks for quotient overflow, the divider stages produce one quotient bit each,
// and the result stage applies sign, saturation and the normal flip. The depth is
// set by the one-bit-per-stage divider. Results leave in the order the rays came in,
// and the receiver cannot hold them off. The plane registers are written through
// cfg_we, cfg_idx and cfg_wdata, and must only be changed while no ray is in flight.
module ray_plane_intersect import rpi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  ray_t        ray,
	output logic        done,
	output res_t        result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	vec_t nrm_q, pnt_q;
	logic dot_vld, div_vld;
	dots_t dots;
	quo_t quo;
	logic done_q;
	res_t res_q;
	res_t res_d;

	// Plane registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_q <= '0;
			pnt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NORMAL_X: nrm_q.x <= cfg_wdata;
				REG_NORMAL_Y: nrm_q.y <= cfg_wdata;
				REG_NORMAL_Z: nrm_q.z <= cfg_wdata;
				REG_POINT_X:  pnt_q.x <= cfg_wdata;
				REG_POINT_Y:  pnt_q.y <= cfg_wdata;
				REG_POINT_Z:  pnt_q.z <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	rpi_dot u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (start),
		.ray    (ray),
		.nrm    (nrm_q),
		.pnt    (pnt_q),
		.vld_o  (dot_vld),
		.dots   (dots)
	);

	rpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (dot_vld),
		.dots   (dots),
		.vld_o  (div_vld),
		.quo    (quo)
	);

	// Sign and saturate the quotient; flip the normal when the ray leaves.
	always_comb begin
		res_d.no_hit = quo.flags.no_hit;
		res_d.leaving = 1'b0;
		res_d.surf_normal_x = nrm_q.x;
		res_d.surf_normal_y = nrm_q.y;
		res_d.surf_normal_z = nrm_q.z;
		priority if (quo.flags.no_hit) begin
			res_d.distance = DIST_MAX;
		end else if (quo.flags.ovf) begin
			res_d.distance = quo.flags.neg ? DIST_MIN : DIST_MAX;
		end else if (quo.flags.neg) begin
			res_d.distance = (quo.quot > DIST_MIN) ? DIST_MIN : 32'(-quo.quot);
		end else begin
			res_d.distance = quo.quot[31] ? DIST_MAX : quo.quot;
		end
		if (!quo.flags.no_hit && quo.flags.leaving) begin
			res_d.leaving = 1'b1;
			res_d.surf_normal_x = (nrm_q.x == DIST_MIN) ? DIST_MAX : 32'(-nrm_q.x);
			res_d.surf_normal_y = (nrm_q.y == DIST_MIN) ? DIST_MAX : 32'(-nrm_q.y);
			res_d.surf_normal_z = (nrm_q.z == DIST_MIN) ? DIST_MAX : 32'(-nrm_q.z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_nohit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.no_hit |-> result.distance == DIST_MAX && !result.leaving)
		else $error("parallel ray without saturated distance");
	a_leave_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.leaving |-> !result.no_hit)
		else $error("leaving flagged on a parallel ray");
	a_enter_nrm: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.leaving |-> result.surf_normal_x == nrm_q.x
			&& result.surf_normal_y == nrm_q.y && result.surf_normal_z == nrm_q.z)
		else $error("normal altered on an entering ray");
`endif

endmodule

/* design/rpi_dot.sv */
// Front end: forms N.D and N.(P0-O) exactly over three pipeline stages.
module rpi_dot import rpi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_i,
	input  ray_t  ray,
	input  vec_t  nrm,
	input  vec_t  pnt,
	output logic  vld_o,
	output dots_t dots
);

	logic vld_s1, vld_s2, vld_s3;
	logic signed [31:0] dx_s1, dy_s1, dz_s1;
	logic signed [32:0] ex_s1, ey_s1, ez_s1;
	logic signed [63:0] pdx_s2, pdy_s2, pdz_s2;
	logic signed [64:0] pnx_s2, pny_s2, pnz_s2;
	dots_t dots_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= ray.dir_x;
		dy_s1 <= ray.dir_y;
		dz_s1 <= ray.dir_z;
		ex_s1 <= 33'(pnt.x) - 33'(ray.origin_x);
		ey_s1 <= 33'(pnt.y) - 33'(ray.origin_y);
		ez_s1 <= 33'(pnt.z) - 33'(ray.origin_z);

		pdx_s2 <= 64'(nrm.x) * 64'(dx_s1);
		pdy_s2 <= 64'(nrm.y) * 64'(dy_s1);
		pdz_s2 <= 64'(nrm.z) * 64'(dz_s1);
		pnx_s2 <= 65'(nrm.x) * 65'(ex_s1);
		pny_s2 <= 65'(nrm.y) * 65'(ey_s1);
		pnz_s2 <= 65'(nrm.z) * 65'(ez_s1);

		dots_s3.den <= 66'(pdx_s2) + 66'(pdy_s2) + 66'(pdz_s2);
		dots_s3.num <= 67'(pnx_s2) + 67'(pny_s2) + 67'(pnz_s2);
	end

	assign vld_o = vld_s3;
	assign dots = dots_s3;

endmodule

/* design/rpi_div.sv */
// Pipelined restoring divider: one quotient bit per stage, plus an overflow check.
module rpi_div import rpi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_i,
	input  dots_t dots,
	output logic  vld_o,
	output quo_t  quo
);

	logic vld_s4;
	logic [DMAG_W-1:0] dmag_s4;
	logic [NSH_W-1:0] nsh_s4;
	dflag_t flg_s4;

	logic vld_s [0:NUM_DIV_STEPS];
	logic [DMAG_W-1:0] dmag_s [0:NUM_DIV_STEPS];
	logic [NSH_W-1:0] rem_s [0:NUM_DIV_STEPS];
	logic [31:0] q_s [0:NUM_DIV_STEPS];
	dflag_t flg_s [0:NUM_DIV_STEPS];

	logic [64:0] nmag;

	assign nmag = dots.num[66] ? 65'(-dots.num) : 65'(dots.num);

	// Magnitudes and signs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		dmag_s4 <= dots.den[65] ? DMAG_W'(-dots.den) : DMAG_W'(dots.den);
		nsh_s4 <= {nmag, 16'b0};
		flg_s4.no_hit <= (dots.den == '0);
		flg_s4.neg <= dots.num[66] ^ dots.den[65];
		flg_s4.leaving <= !dots.den[65];
		flg_s4.ovf <= 1'b0;
	end

	// A quotient of 2^32 or more saturates either way.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		dmag_s[0] <= dmag_s4;
		rem_s[0] <= nsh_s4;
		q_s[0] <= '0;
		flg_s[0].no_hit <= flg_s4.no_hit;
		flg_s[0].neg <= flg_s4.neg;
		flg_s[0].leaving <= flg_s4.leaving;
		flg_s[0].ovf <= {15'b0, nsh_s4} >= {dmag_s4, 32'b0};
	end

	for (genvar k = 0; k < NUM_DIV_STEPS; k++) begin : g_step
		logic [CMP_W-1:0] dsh;
		logic ge;

		assign dsh = CMP_W'(dmag_s[k]) << (NUM_DIV_STEPS - 1 - k);
		assign ge = {15'b0, rem_s[k]} >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dmag_s[k+1] <= dmag_s[k];
			rem_s[k+1] <= ge ? rem_s[k] - dsh[NSH_W-1:0] : rem_s[k];
			q_s[k+1] <= {q_s[k][30:0], ge};
			flg_s[k+1] <= flg_s[k];
		end
	end

	assign vld_o = vld_s[NUM_DIV_STEPS];
	assign quo.quot = q_s[NUM_DIV_STEPS];
	assign quo.flags = flg_s[NUM_DIV_STEPS];

endmodule
